FILE: src/adll_pkg.sv
package adll_pkg;

  localparam int MAX_NODES = 1022;
  localparam int VAL_W     = 32;
  localparam int SLOT_W    = 10;
  localparam int ACT_W     = 3;
  localparam int STAT_W    = 2;

  localparam logic [SLOT_W-1:0] HEAD_SLOT = SLOT_W'(0);
  localparam logic [SLOT_W-1:0] TAIL_SLOT = SLOT_W'(1);

  localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_INS_RIGHT  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_INS_LEFT   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_REMOVE     = 3'd4;
  localparam logic [ACT_W-1:0] ACT_READ       = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD  = 2'd2;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [SLOT_W-1:0] wdata;
    logic [SLOT_W-1:0] raddr;
  } link_req_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [VAL_W-1:0]  wdata;
    logic [SLOT_W-1:0] raddr;
  } val_req_t;

endpackage

FILE: src/adll_ram.sv
module adll_ram #(
  parameter int AW = 10,
  parameter int DW = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/adll_ctrl.sv
module adll_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [adll_pkg::ACT_W-1:0]     in_action,
  input  logic [adll_pkg::SLOT_W-1:0]    in_node,
  input  logic signed [adll_pkg::VAL_W-1:0] in_item_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [adll_pkg::STAT_W-1:0]    out_status,
  output logic [adll_pkg::SLOT_W-1:0]    out_new_node,
  output logic [adll_pkg::SLOT_W-1:0]    out_follower_node,
  output logic signed [adll_pkg::VAL_W-1:0] out_follower_value,
  output logic                           out_at_end,
  output adll_pkg::link_req_t            nx_req,
  input  logic [adll_pkg::SLOT_W-1:0]    nx_rdata,
  output adll_pkg::link_req_t            pv_req,
  input  logic [adll_pkg::SLOT_W-1:0]    pv_rdata,
  output adll_pkg::val_req_t             vl_req,
  input  logic [adll_pkg::VAL_W-1:0]     vl_rdata
);

  localparam int SLOT_W = adll_pkg::SLOT_W;
  localparam int VAL_W  = adll_pkg::VAL_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD1  = 3'd1;
  localparam logic [2:0] S_RD2  = 3'd2;
  localparam logic [2:0] S_WR1  = 3'd3;
  localparam logic [2:0] S_WR2  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]                    state_r, state_nxt;
  logic [adll_pkg::ACT_W-1:0]    act_r;
  logic [SLOT_W-1:0]             slot_r;
  logic [VAL_W-1:0]              val_r;
  logic                          go_r;
  logic [adll_pkg::STAT_W-1:0]   status_r;
  logic [SLOT_W-1:0]             a_r, succ_r, f_r, new_r;
  logic [VAL_W-1:0]              fval_r;
  logic [SLOT_W-1:0]             ng_r;
  logic                          nx0_set_r, pv1_set_r;
  logic                          nx_hit_r, pv_hit_r;

  logic                          out_valid_r;
  logic [adll_pkg::STAT_W-1:0]   out_status_r;
  logic [SLOT_W-1:0]             out_new_r, out_fnode_r;
  logic [VAL_W-1:0]              out_fval_r;
  logic                          out_end_r;

  logic                          accept;
  logic                          node_ok, full;
  logic [adll_pkg::STAT_W-1:0]   status_in;
  logic                          known_act;
  logic [SLOT_W-1:0]             next_rd, prev_rd, fresh_slot;
  logic                          is_rd, out_free;

  assign accept     = in_valid && in_ready;
  assign in_ready   = (state_r == S_IDLE);
  assign out_free   = !out_valid_r || out_ready;
  assign fresh_slot = ng_r + SLOT_W'(2);

  // slot 0 next and slot 1 prev read their reset links until first written
  assign next_rd = nx_hit_r ? adll_pkg::TAIL_SLOT : nx_rdata;
  assign prev_rd = pv_hit_r ? adll_pkg::HEAD_SLOT : pv_rdata;

  assign node_ok   = (in_node != SLOT_W'(0)) && (in_node <= ng_r);
  assign full      = (ng_r >= SLOT_W'(adll_pkg::MAX_NODES));
  assign known_act = (in_action <= adll_pkg::ACT_READ);

  always_comb begin
    status_in = adll_pkg::ST_OK;
    unique case (in_action)
      adll_pkg::ACT_PUSH_FRONT, adll_pkg::ACT_PUSH_BACK: begin
        if (full) status_in = adll_pkg::ST_FULL;
      end
      adll_pkg::ACT_INS_RIGHT, adll_pkg::ACT_INS_LEFT: begin
        if (!node_ok) status_in = adll_pkg::ST_BAD;
        else if (full) status_in = adll_pkg::ST_FULL;
      end
      adll_pkg::ACT_REMOVE: begin
        if (!node_ok) status_in = adll_pkg::ST_BAD;
      end
      adll_pkg::ACT_READ: begin
        if (in_node > ng_r) status_in = adll_pkg::ST_BAD;
      end
      default: status_in = adll_pkg::ST_OK;
    endcase
  end

  // memory ports
  always_comb begin
    nx_req = '0;
    pv_req = '0;
    vl_req = '0;
    unique case (state_r)
      S_IDLE: begin
        if ((in_action == adll_pkg::ACT_PUSH_FRONT) ||
            ((in_action == adll_pkg::ACT_READ) && (in_node == SLOT_W'(0)))) begin
          nx_req.raddr = adll_pkg::HEAD_SLOT;
        end else begin
          nx_req.raddr = in_node + SLOT_W'(1);
        end
        if (in_action == adll_pkg::ACT_PUSH_BACK) begin
          pv_req.raddr = adll_pkg::TAIL_SLOT;
        end else begin
          pv_req.raddr = in_node + SLOT_W'(1);
        end
      end
      S_RD1: begin
        nx_req.raddr = prev_rd;
        vl_req.raddr = next_rd;
        if (go_r && (act_r == adll_pkg::ACT_REMOVE)) begin
          nx_req.we    = 1'b1;
          nx_req.waddr = prev_rd;
          nx_req.wdata = next_rd;
          pv_req.we    = 1'b1;
          pv_req.waddr = next_rd;
          pv_req.wdata = prev_rd;
        end
      end
      S_WR1: begin
        nx_req.we    = 1'b1;
        nx_req.waddr = fresh_slot;
        nx_req.wdata = succ_r;
        pv_req.we    = 1'b1;
        pv_req.waddr = fresh_slot;
        pv_req.wdata = a_r;
        vl_req.we    = 1'b1;
        vl_req.waddr = fresh_slot;
        vl_req.wdata = val_r;
      end
      S_WR2: begin
        nx_req.we    = 1'b1;
        nx_req.waddr = a_r;
        nx_req.wdata = fresh_slot;
        pv_req.we    = 1'b1;
        pv_req.waddr = succ_r;
        pv_req.wdata = fresh_slot;
      end
      default: begin
        nx_req = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_RD1;
      end
      S_RD1: begin
        if (!go_r) begin
          state_nxt = S_DONE;
        end else begin
          unique case (act_r)
            adll_pkg::ACT_PUSH_FRONT, adll_pkg::ACT_INS_RIGHT: state_nxt = S_WR1;
            adll_pkg::ACT_PUSH_BACK, adll_pkg::ACT_INS_LEFT:   state_nxt = S_RD2;
            adll_pkg::ACT_READ:                                state_nxt = S_RD2;
            default:                                           state_nxt = S_DONE;
          endcase
        end
      end
      S_RD2: begin
        state_nxt = (act_r == adll_pkg::ACT_READ) ? S_DONE : S_WR1;
      end
      S_WR1: state_nxt = S_WR2;
      S_WR2: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ng_r      <= '0;
      nx0_set_r <= 1'b0;
      pv1_set_r <= 1'b0;
      nx_hit_r  <= 1'b0;
      pv_hit_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      nx_hit_r <= (nx_req.raddr == adll_pkg::HEAD_SLOT) && !nx0_set_r;
      pv_hit_r <= (pv_req.raddr == adll_pkg::TAIL_SLOT) && !pv1_set_r;
      if (nx_req.we && (nx_req.waddr == adll_pkg::HEAD_SLOT)) nx0_set_r <= 1'b1;
      if (pv_req.we && (pv_req.waddr == adll_pkg::TAIL_SLOT)) pv1_set_r <= 1'b1;
      if (state_r == S_WR2) ng_r <= ng_r + SLOT_W'(1);
    end
  end

  // per-transaction working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r    <= in_action;
      val_r    <= in_item_value;
      status_r <= status_in;
      go_r     <= known_act && (status_in == adll_pkg::ST_OK);
      slot_r   <= (in_action == adll_pkg::ACT_PUSH_FRONT) ? adll_pkg::HEAD_SLOT
                                                          : in_node + SLOT_W'(1);
      new_r    <= '0;
    end
    if (state_r == S_RD1) begin
      a_r    <= (act_r == adll_pkg::ACT_PUSH_BACK || act_r == adll_pkg::ACT_INS_LEFT)
                ? prev_rd : slot_r;
      succ_r <= next_rd;
      f_r    <= next_rd;
    end
    if (state_r == S_RD2) begin
      succ_r <= next_rd;
      fval_r <= vl_rdata;
    end
    if (state_r == S_WR2) begin
      new_r <= ng_r + SLOT_W'(1);
    end
  end

  assign is_rd = go_r && (act_r == adll_pkg::ACT_READ);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_DONE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_DONE) && out_free) begin
      out_status_r <= status_r;
      out_new_r    <= new_r;
      out_end_r    <= is_rd && (f_r == adll_pkg::TAIL_SLOT);
      if (is_rd && (f_r >= SLOT_W'(2))) begin
        out_fnode_r <= f_r - SLOT_W'(1);
        out_fval_r  <= fval_r;
      end else begin
        out_fnode_r <= '0;
        out_fval_r  <= '0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_new_node       = out_new_r;
  assign out_follower_node  = out_fnode_r;
  assign out_follower_value = out_fval_r;
  assign out_at_end         = out_end_r;

endmodule

FILE: src/array_doubly_linked_list_core.sv
// channel   direction  handshake             payload
// in_       input      in_valid / in_ready   action, node, item_value
// out_      output     out_valid / out_ready status, new_node, follower_node,
//                                            follower_value, at_end
//
// one transaction at a time through synchronous next, prev and value rams
// states after accept: RD1, DONE for remove, unknown, bad or full requests; RD1, RD2,
// DONE for reads; RD1, optional RD2, WR1, WR2, DONE for inserts (one or two link reads)
// reset clears the node counter and restores the head and tail links at once
// a result waits in the output register; while it is stalled the next transaction
// waits in its last step with in_ready low
module array_doubly_linked_list_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [adll_pkg::ACT_W-1:0]        in_action,
  input  logic [adll_pkg::SLOT_W-1:0]       in_node,
  input  logic signed [adll_pkg::VAL_W-1:0] in_item_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [adll_pkg::STAT_W-1:0]       out_status,
  output logic [adll_pkg::SLOT_W-1:0]       out_new_node,
  output logic [adll_pkg::SLOT_W-1:0]       out_follower_node,
  output logic signed [adll_pkg::VAL_W-1:0] out_follower_value,
  output logic                              out_at_end
);

  adll_pkg::link_req_t              nx_req, pv_req;
  adll_pkg::val_req_t               vl_req;
  logic [adll_pkg::SLOT_W-1:0]      nx_rdata, pv_rdata;
  logic [adll_pkg::VAL_W-1:0]       vl_rdata;

  adll_ctrl u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_action          (in_action),
    .in_node            (in_node),
    .in_item_value      (in_item_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_new_node       (out_new_node),
    .out_follower_node  (out_follower_node),
    .out_follower_value (out_follower_value),
    .out_at_end         (out_at_end),
    .nx_req             (nx_req),
    .nx_rdata           (nx_rdata),
    .pv_req             (pv_req),
    .pv_rdata           (pv_rdata),
    .vl_req             (vl_req),
    .vl_rdata           (vl_rdata)
  );

  adll_ram #(.AW(adll_pkg::SLOT_W), .DW(adll_pkg::SLOT_W)) u_next_ram (
    .clk   (clk),
    .we    (nx_req.we),
    .waddr (nx_req.waddr),
    .wdata (nx_req.wdata),
    .raddr (nx_req.raddr),
    .rdata (nx_rdata)
  );

  adll_ram #(.AW(adll_pkg::SLOT_W), .DW(adll_pkg::SLOT_W)) u_prev_ram (
    .clk   (clk),
    .we    (pv_req.we),
    .waddr (pv_req.waddr),
    .wdata (pv_req.wdata),
    .raddr (pv_req.raddr),
    .rdata (pv_rdata)
  );

  adll_ram #(.AW(adll_pkg::SLOT_W), .DW(adll_pkg::VAL_W)) u_value_ram (
    .clk   (clk),
    .we    (vl_req.we),
    .waddr (vl_req.waddr),
    .wdata (vl_req.wdata),
    .raddr (vl_req.raddr),
    .rdata (vl_rdata)
  );

endmodule

FILE: tb/array_doubly_linked_list_core_tb.sv
`timescale 1ns / 100ps

module array_doubly_linked_list_core_tb;

  localparam int SLOT_W    = adll_pkg::SLOT_W;
  localparam int ACT_W     = adll_pkg::ACT_W;
  localparam int STAT_W    = adll_pkg::STAT_W;
  localparam int VAL_W     = adll_pkg::VAL_W;
  localparam int MAX_NODES = adll_pkg::MAX_NODES;

  localparam int ITEM_TARGET = 1950;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_EVERY = 400;
  localparam int SLOTS = 1 << SLOT_W;
  localparam logic [ACT_W-1:0] ACT_NOP_A = 3'd6;
  localparam logic [ACT_W-1:0] ACT_NOP_B = 3'd7;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] new_node;
    logic [SLOT_W-1:0] follower_node;
    logic [VAL_W-1:0]  follower_value;
    logic              at_end;
  } list_result_t;

  typedef struct {
    logic [ACT_W-1:0]  action;
    logic [SLOT_W-1:0] node;
    logic [VAL_W-1:0]  value;
    bit                drain;
  } list_cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [ACT_W-1:0] in_action = '0;
  logic [SLOT_W-1:0] in_node = '0;
  logic signed [VAL_W-1:0] in_item_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STAT_W-1:0] out_status;
  logic [SLOT_W-1:0] out_new_node;
  logic [SLOT_W-1:0] out_follower_node;
  logic signed [VAL_W-1:0] out_follower_value;
  logic out_at_end;

  array_doubly_linked_list_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_action          (in_action),
    .in_node            (in_node),
    .in_item_value      (in_item_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_new_node       (out_new_node),
    .out_follower_node  (out_follower_node),
    .out_follower_value (out_follower_value),
    .out_at_end         (out_at_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // list model: slot 0 head, slot 1 tail, node k in slot k+1
  logic [SLOT_W-1:0] next_slot [SLOTS];
  logic [SLOT_W-1:0] prev_slot [SLOTS];
  logic [VAL_W-1:0]  slot_value [SLOTS];
  int list_count;

  list_cmd_t pending_cmds [$];
  list_result_t expected_results [$];
  list_cmd_t cur_cmd;

  int gen_count;
  int n_items;
  int mismatch_cnt;
  int results_seen;
  int cycle_cnt;
  int burst_left;
  int gap_left;
  int rx_mode;
  logic in_taken;

  function automatic logic [SLOT_W-1:0] link_new_node(input logic [SLOT_W-1:0] after,
                                                      input logic [VAL_W-1:0] v);
    logic [SLOT_W-1:0] fresh;
    logic [SLOT_W-1:0] succ;
    list_count++;
    fresh = SLOT_W'(list_count + 1);
    succ = next_slot[after];
    slot_value[fresh] = v;
    next_slot[fresh] = succ;
    prev_slot[fresh] = after;
    prev_slot[succ] = fresh;
    next_slot[after] = fresh;
    return SLOT_W'(list_count);
  endfunction

  function automatic list_result_t predict_list_op(input logic [ACT_W-1:0] act,
                                                   input logic [SLOT_W-1:0] k,
                                                   input logic [VAL_W-1:0] v);
    list_result_t r;
    logic [SLOT_W-1:0] s;
    logic [SLOT_W-1:0] f;
    logic [SLOT_W-1:0] lft;
    logic [SLOT_W-1:0] rgt;
    bit k_ok;
    bit full;
    r = '0;
    k_ok = (k >= 1) && (k <= list_count);
    full = list_count >= MAX_NODES;
    s = k + SLOT_W'(1);
    case (act)
      adll_pkg::ACT_PUSH_FRONT, adll_pkg::ACT_PUSH_BACK: begin
        if (full) r.status = adll_pkg::ST_FULL;
        else r.new_node = link_new_node(act == adll_pkg::ACT_PUSH_FRONT
                                        ? adll_pkg::HEAD_SLOT
                                        : prev_slot[adll_pkg::TAIL_SLOT], v);
      end
      adll_pkg::ACT_INS_RIGHT, adll_pkg::ACT_INS_LEFT: begin
        if (!k_ok) r.status = adll_pkg::ST_BAD;
        else if (full) r.status = adll_pkg::ST_FULL;
        else r.new_node = link_new_node(act == adll_pkg::ACT_INS_RIGHT ? s : prev_slot[s], v);
      end
      adll_pkg::ACT_REMOVE: begin
        if (!k_ok) begin
          r.status = adll_pkg::ST_BAD;
        end else begin
          // stale links of a removed node are followed as they stand
          lft = prev_slot[s];
          rgt = next_slot[s];
          next_slot[lft] = rgt;
          prev_slot[rgt] = lft;
        end
      end
      adll_pkg::ACT_READ: begin
        if (k > list_count) begin
          r.status = adll_pkg::ST_BAD;
        end else begin
          f = next_slot[k == 0 ? adll_pkg::HEAD_SLOT : s];
          if (f == adll_pkg::TAIL_SLOT) begin
            r.at_end = 1'b1;
          end else if (f != adll_pkg::HEAD_SLOT) begin
            r.follower_node = f - SLOT_W'(1);
            r.follower_value = slot_value[f];
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // stimulus side keeps its own node count to choose valid and invalid numbers
  task automatic queue_cmd(input logic [ACT_W-1:0] act, input int k,
                           input logic [VAL_W-1:0] v, input bit drain);
    list_cmd_t c;
    c.action = act;
    c.node = SLOT_W'(k);
    c.value = v;
    c.drain = drain;
    pending_cmds.push_back(c);
    if (gen_count < MAX_NODES) begin
      if (act == adll_pkg::ACT_PUSH_FRONT || act == adll_pkg::ACT_PUSH_BACK) gen_count++;
      else if ((act == adll_pkg::ACT_INS_RIGHT || act == adll_pkg::ACT_INS_LEFT) &&
               k >= 1 && k <= gen_count)
        gen_count++;
    end
    if (act <= adll_pkg::ACT_READ) n_items++;
  endtask

  function automatic logic [VAL_W-1:0] rand_word();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return '1;
      2: return 32'h7fff_ffff;
      3: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_node(input bit for_read);
    if (gen_count == 0 || $urandom_range(0, 9) == 0) begin
      if (!for_read && $urandom_range(0, 2) == 0) return 0;
      return $urandom_range(gen_count + 1, SLOTS - 1);
    end
    if (for_read && $urandom_range(0, 7) == 0) return 0;
    if ($urandom_range(0, 3) == 0)
      return $urandom_range(gen_count > 8 ? gen_count - 8 : 1, gen_count);
    return $urandom_range(1, gen_count);
  endfunction

  task automatic random_op(input bit filling, input bit force_drain);
    logic [ACT_W-1:0] insert_ops [4];
    logic [ACT_W-1:0] act;
    int ins_pct;
    int r;
    int k;
    bit drain;
    insert_ops = '{adll_pkg::ACT_PUSH_FRONT, adll_pkg::ACT_PUSH_BACK,
                   adll_pkg::ACT_INS_RIGHT, adll_pkg::ACT_INS_LEFT};
    ins_pct = filling ? 80 : 30;
    r = $urandom_range(0, 99);
    drain = force_drain || (n_items % DRAIN_EVERY == DRAIN_EVERY - 1);
    if (r < 2) begin
      act = $urandom_range(0, 1) ? ACT_NOP_A : ACT_NOP_B;
      k = $urandom_range(0, SLOTS - 1);
    end else if (r < ins_pct) begin
      act = insert_ops[$urandom_range(0, 3)];
      if (act == adll_pkg::ACT_PUSH_FRONT || act == adll_pkg::ACT_PUSH_BACK)
        k = $urandom_range(0, SLOTS - 1);
      else k = pick_node(1'b0);
    end else if (r < ins_pct + (100 - ins_pct) / 2) begin
      act = adll_pkg::ACT_REMOVE;
      k = pick_node(1'b0);
    end else begin
      act = adll_pkg::ACT_READ;
      k = pick_node(1'b1);
    end
    queue_cmd(act, k, rand_word(), drain);
  endtask

  // sender: bursts and gaps, optional hold-off until all results are back; four randomly chosen out_ready modes
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (cycle_cnt % 128 == 0) rx_mode <= $urandom_range(0, 3);
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 9) < 7);
        2: out_ready <= ($urandom_range(0, 15) == 0);
        default: out_ready <= ((cycle_cnt % 7) < 3);
      endcase

      if (in_valid && !in_taken) begin
        // hold the transaction until it is taken
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_cmds.size() == 0 ||
                   (pending_cmds[0].drain && expected_results.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        cur_cmd = pending_cmds.pop_front();
        in_valid <= 1'b1;
        in_action <= cur_cmd.action;
        in_node <= cur_cmd.node;
        in_item_value <= cur_cmd.value;
        if (burst_left <= 1) begin
          if ($urandom_range(0, 9) == 0) begin
            burst_left <= $urandom_range(100, 300);
            gap_left <= 0;
          end else begin
            burst_left <= $urandom_range(1, 30);
            gap_left <= $urandom_range(1, 8);
          end
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // accepted inputs feed the model, accepted results are checked in order
  always @(posedge clk) begin
    list_result_t got;
    list_result_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready)
        expected_results.push_back(predict_list_op(in_action, in_node, in_item_value));
      if (out_valid && out_ready) begin
        got = '{out_status, out_new_node, out_follower_node, out_follower_value, out_at_end};
        results_seen++;
        if (expected_results.size() == 0) begin
          if (mismatch_cnt < 10)
            $display("error: result %0d arrived with nothing expected", results_seen);
          mismatch_cnt++;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            if (mismatch_cnt < 10)
              $display({"error: result %0d status %0d/%0d new %0d/%0d follower %0d/%0d ",
                        "value %h/%h end %b/%b (expected/actual)"},
                       results_seen, want.status, got.status, want.new_node, got.new_node,
                       want.follower_node, got.follower_node, want.follower_value,
                       got.follower_value, want.at_end, got.at_end);
            mismatch_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      next_slot[i] = '0;
      prev_slot[i] = '0;
      slot_value[i] = '0;
    end
    next_slot[adll_pkg::HEAD_SLOT] = adll_pkg::TAIL_SLOT;
    prev_slot[adll_pkg::TAIL_SLOT] = adll_pkg::HEAD_SLOT;
    list_count = 0;
    gen_count = 0;
    n_items = 0;
    mismatch_cnt = 0;
    results_seen = 0;
    cycle_cnt = 0;
    burst_left = 0;
    gap_left = 0;
    rx_mode = 0;

    // empty list: head follows straight to tail, every node number from 1 is invalid; then pushes, inserts and reads
    queue_cmd(adll_pkg::ACT_READ, 0, '0, 1'b0);
    queue_cmd(adll_pkg::ACT_READ, 1, '0, 1'b0);
    queue_cmd(adll_pkg::ACT_REMOVE, 0, '0, 1'b0);
    queue_cmd(adll_pkg::ACT_INS_RIGHT, 1, '1, 1'b0);
    queue_cmd(adll_pkg::ACT_INS_LEFT, 1, '1, 1'b0);
    queue_cmd(adll_pkg::ACT_PUSH_FRONT, 0, 32'h7fff_ffff, 1'b0);
    queue_cmd(adll_pkg::ACT_PUSH_BACK, SLOTS - 1, 32'h8000_0000, 1'b0);
    queue_cmd(adll_pkg::ACT_INS_RIGHT, 1, '1, 1'b0);
    queue_cmd(adll_pkg::ACT_INS_LEFT, 1, '0, 1'b0);
    queue_cmd(adll_pkg::ACT_READ, 0, '0, 1'b0);
    queue_cmd(adll_pkg::ACT_READ, 1, '0, 1'b0);
    queue_cmd(adll_pkg::ACT_READ, 2, '0, 1'b0);
    // removed node: reads, removes and inserts follow its stale links; then unknown actions and out-of-range nodes
    queue_cmd(adll_pkg::ACT_REMOVE, 1, '0, 1'b0);
    queue_cmd(adll_pkg::ACT_READ, 4, '0, 1'b0);
    queue_cmd(adll_pkg::ACT_READ, 1, '0, 1'b0);
    queue_cmd(adll_pkg::ACT_REMOVE, 1, '0, 1'b0);
    queue_cmd(adll_pkg::ACT_INS_RIGHT, 1, 32'h1234_5678, 1'b0);
    queue_cmd(adll_pkg::ACT_INS_LEFT, 1, 32'hdead_beef, 1'b0);
    queue_cmd(adll_pkg::ACT_READ, 0, '0, 1'b0);
    queue_cmd(ACT_NOP_A, SLOTS - 1, '1, 1'b0);
    queue_cmd(ACT_NOP_B, 0, '0, 1'b0);
    queue_cmd(adll_pkg::ACT_READ, SLOTS - 1, '0, 1'b0);
    queue_cmd(adll_pkg::ACT_REMOVE, gen_count + 1, '0, 1'b0);
    queue_cmd(adll_pkg::ACT_REMOVE, 2, '0, 1'b0);
    queue_cmd(adll_pkg::ACT_PUSH_BACK, 0, 32'h0000_0001, 1'b0);
    queue_cmd(adll_pkg::ACT_READ, gen_count, '0, 1'b0);

    // fill the store with insert-heavy traffic, then keep working while full
    while (gen_count < MAX_NODES) random_op(1'b1, 1'b0);
    random_op(1'b0, 1'b1);
    while (n_items < ITEM_TARGET) random_op(1'b0, 1'b0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() != 0 || in_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatch_cnt == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: files.f
src/adll_pkg.sv
src/adll_ram.sv
src/adll_ctrl.sv
src/array_doubly_linked_list_core.sv
tb/array_doubly_linked_list_core_tb.sv
